/* design/mavg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mavg_pkg
// shared constants, types and register map of the moving average filter
// ============================================================================
package mavg_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_BITS  = 24;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int LEN_BITS    = SLOT_BITS + 1;
    localparam int SUM_BITS    = PRICE_BITS + SLOT_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int ACC_BITS    = PRICE_BITS + FRAC_BITS;
    localparam int HI_BITS     = ACC_BITS - FRAC_BITS;
    localparam int PROD_BITS   = HI_BITS + WEIGHT_BITS;
    localparam int LO_BITS     = FRAC_BITS + WEIGHT_BITS;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 3;

    localparam logic [LEN_BITS-1:0]    LEN_RESET    = LEN_BITS'(5);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(21845);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = WEIGHT_BITS'(1 << FRAC_BITS);

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_WINDOW_LENGTH = 1'b0,
        REG_EMA_WEIGHT    = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_DIFF,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic load;     // latch the accepted transaction
        logic restart;  // window_length written: clear the series
        logic read;     // optional clear, fetch the leaving sample
        logic sum;      // update window sum, store sample, start divide
        logic div_step; // one restoring divide step
        logic diff;     // ema difference and sign
        logic mul;      // weight products
        logic upd;      // ema update or seed
        logic out_load; // load the result registers
    } mavg_cmd_t;

endpackage

`default_nettype wire

/* design/moving_average_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// moving_average_filter
// simple and exponential moving average of an unsigned Q16.8 price stream
// ============================================================================
// usage
//   input channel: one transaction per price sample (price_sample plus
//   series_start), taken when in_valid is high and in_stall is low
//   output channel: one transaction per sample (sma/ema values and flags),
//   taken when out_valid is high and out_stall is low
//   apb port: window_length at byte address 0, ema_weight at address 4
//   sequencing: in_stall is high until the previous sample's result is
//   loaded into the output register; each sample passes load, ring read,
//   sum update, the 30 step restoring divide of the window sum (one
//   quotient bit per cycle), ema difference, multiply, update and output load
//   a stalled result sits in the output register; the next sample is
//   taken meanwhile and its result waits in the sequencer until the
//   output register empties
//   reset clears the series state, the sample count and the ema, and sets
//   window_length to 5 and ema_weight to 21845; the sample ring needs no
//   clearing since only samples of the current series are read back
//   writing window_length restarts the series like series_start
// ============================================================================
module moving_average_filter
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [mavg_pkg::PRICE_BITS-1:0]      price_sample,
    input  wire logic                                 series_start,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      sma_valid,
    output logic [mavg_pkg::PRICE_BITS-1:0]           sma_value,
    output logic                                      ema_valid,
    output logic [mavg_pkg::PRICE_BITS-1:0]           ema_value,
    // apb configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mavg_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [mavg_pkg::DATA_BITS-1:0]       pwdata,
    output logic [mavg_pkg::DATA_BITS-1:0]            prdata,
    output logic                                      pready
);

    logic [mavg_pkg::LEN_BITS-1:0]      len_reg;
    logic [mavg_pkg::LEN_BITS-1:0]      len_next;
    logic [mavg_pkg::WEIGHT_BITS-1:0]   weight_reg;
    logic [mavg_pkg::WEIGHT_BITS-1:0]   weight_next;
    logic [mavg_pkg::LEN_BITS-1:0]      eff_len;
    logic [mavg_pkg::WEIGHT_BITS-1:0]   eff_weight;
    logic                               cfg_write;
    logic                               cfg_restart;
    mavg_pkg::reg_index_t               reg_index;
    mavg_pkg::mavg_cmd_t                cmd;

    // register access, word aligned; low address bits are not decoded
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = mavg_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        len_next    = len_reg;
        weight_next = weight_reg;
        cfg_restart = 1'b0;
        if (cfg_write)
        begin
            unique case (reg_index)
                mavg_pkg::REG_WINDOW_LENGTH:
                begin
                    len_next    = pwdata[mavg_pkg::LEN_BITS-1:0];
                    cfg_restart = 1'b1;
                end
                mavg_pkg::REG_EMA_WEIGHT:
                begin
                    weight_next = pwdata[mavg_pkg::WEIGHT_BITS-1:0];
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mavg_pkg::REG_WINDOW_LENGTH:
                prdata = mavg_pkg::DATA_BITS'(len_reg);
            mavg_pkg::REG_EMA_WEIGHT:
                prdata = mavg_pkg::DATA_BITS'(weight_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= mavg_pkg::LEN_RESET;
            weight_reg <= mavg_pkg::WEIGHT_RESET;
        end
        else
        begin
            len_reg    <= len_next;
            weight_reg <= weight_next;
        end
    end

    // zero length acts as one, longer than the ring saturates
    always_comb
    begin
        if (len_reg == '0)
            eff_len = mavg_pkg::LEN_BITS'(1);
        else if (len_reg > mavg_pkg::LEN_BITS'(mavg_pkg::MAX_WINDOW))
            eff_len = mavg_pkg::LEN_BITS'(mavg_pkg::MAX_WINDOW);
        else
            eff_len = len_reg;
    end

    // weight above 1.0 saturates
    assign eff_weight = (weight_reg > mavg_pkg::WEIGHT_ONE) ? mavg_pkg::WEIGHT_ONE
                                                            : weight_reg;

    mavg_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_restart (cfg_restart),
        .cmd         (cmd)
    );

    mavg_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .price_sample (price_sample),
        .series_start (series_start),
        .eff_len      (eff_len),
        .eff_weight   (eff_weight),
        .sma_valid    (sma_valid),
        .sma_value    (sma_value),
        .ema_valid    (ema_valid),
        .ema_value    (ema_value)
    );

endmodule

`default_nettype wire

/* design/mavg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mavg_ctrl
// sequencer of the moving average filter: handshakes and step commands
// ============================================================================
module mavg_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire logic               cfg_restart,
    output mavg_pkg::mavg_cmd_t     cmd
);

    mavg_pkg::state_t                   state_reg;
    mavg_pkg::state_t                   state_next;
    logic [mavg_pkg::CNT_BITS-1:0]      cnt_reg;
    logic [mavg_pkg::CNT_BITS-1:0]      cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mavg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.restart    = cfg_restart;
        unique case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mavg_pkg::ST_READ;
                end
            end
            mavg_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = mavg_pkg::ST_SUM;
            end
            mavg_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = mavg_pkg::CNT_BITS'(mavg_pkg::DIV_STEPS - 1);
                state_next = mavg_pkg::ST_DIV;
            end
            mavg_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = mavg_pkg::ST_DIFF;
            end
            mavg_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = mavg_pkg::ST_MUL;
            end
            mavg_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = mavg_pkg::ST_UPD;
            end
            mavg_pkg::ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = mavg_pkg::ST_OUT;
            end
            mavg_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavg_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != mavg_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/mavg_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mavg_dpath
// sample ring, window sum, restoring divider and ema update
// ============================================================================
module mavg_dpath
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mavg_pkg::mavg_cmd_t                 cmd,
    input  wire logic [mavg_pkg::PRICE_BITS-1:0]     price_sample,
    input  wire logic                                series_start,
    input  wire logic [mavg_pkg::LEN_BITS-1:0]       eff_len,
    input  wire logic [mavg_pkg::WEIGHT_BITS-1:0]    eff_weight,
    output logic                                     sma_valid,
    output logic [mavg_pkg::PRICE_BITS-1:0]          sma_value,
    output logic                                     ema_valid,
    output logic [mavg_pkg::PRICE_BITS-1:0]          ema_value
);

    // sample ring
    logic [mavg_pkg::PRICE_BITS-1:0]   ring_mem [mavg_pkg::MAX_WINDOW];
    logic [mavg_pkg::PRICE_BITS-1:0]   rdata_reg;
    logic [mavg_pkg::SLOT_BITS-1:0]    old_slot;

    // series state
    logic [mavg_pkg::SLOT_BITS-1:0]    slot_reg;
    logic [mavg_pkg::SLOT_BITS-1:0]    slot_next;
    logic [mavg_pkg::SUM_BITS-1:0]     sum_reg;
    logic [mavg_pkg::SUM_BITS-1:0]     sum_next;
    logic [mavg_pkg::LEN_BITS-1:0]     count_reg;
    logic [mavg_pkg::LEN_BITS-1:0]     count_next;
    logic [mavg_pkg::ACC_BITS-1:0]     acc_reg;
    logic [mavg_pkg::ACC_BITS-1:0]     acc_next;
    logic                              seeded_reg;
    logic                              seeded_next;
    logic                              clear;

    // per transaction working registers
    logic [mavg_pkg::PRICE_BITS-1:0]   price_reg;
    logic                              start_reg;
    logic                              sma_ok_reg;
    logic [mavg_pkg::SUM_BITS-1:0]     quot_reg;
    logic [mavg_pkg::LEN_BITS-1:0]     rem_reg;
    logic [mavg_pkg::LEN_BITS:0]       rem_shift;
    logic [mavg_pkg::LEN_BITS:0]       rem_diff;
    logic                              rem_ge;
    logic [mavg_pkg::ACC_BITS-1:0]     target;
    logic [mavg_pkg::ACC_BITS-1:0]     diff_reg;
    logic                              neg_reg;
    logic [mavg_pkg::PROD_BITS-1:0]    p_hi_reg;
    logic [mavg_pkg::LO_BITS-1:0]      p_lo_full;
    logic [mavg_pkg::WEIGHT_BITS-1:0]  p_lo_reg;
    logic [mavg_pkg::PROD_BITS-1:0]    scale;

    // result registers
    logic                              sma_valid_reg;
    logic [mavg_pkg::PRICE_BITS-1:0]   sma_value_reg;
    logic                              ema_valid_reg;
    logic [mavg_pkg::PRICE_BITS-1:0]   ema_value_reg;

    assign old_slot = slot_reg - eff_len[mavg_pkg::SLOT_BITS-1:0];
    assign clear    = cmd.restart || (cmd.read && start_reg);
    assign target   = {price_reg, mavg_pkg::FRAC_BITS'(0)};

    assign rem_shift = {rem_reg, quot_reg[mavg_pkg::SUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, eff_len};
    assign rem_ge    = (rem_shift >= {1'b0, eff_len});

    assign p_lo_full = mavg_pkg::LO_BITS'(diff_reg[mavg_pkg::FRAC_BITS-1:0])
                       * mavg_pkg::LO_BITS'(eff_weight);
    assign scale     = p_hi_reg + mavg_pkg::PROD_BITS'(p_lo_reg);

    always_comb
    begin
        slot_next   = slot_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        seeded_next = seeded_reg;
        if (clear)
        begin
            sum_next    = '0;
            count_next  = '0;
            acc_next    = '0;
            seeded_next = 1'b0;
        end
        if (cmd.sum)
        begin
            // drop the leaving sample once the window is full
            if (count_reg >= eff_len)
                sum_next = sum_reg - mavg_pkg::SUM_BITS'(rdata_reg)
                           + mavg_pkg::SUM_BITS'(price_reg);
            else
                sum_next = sum_reg + mavg_pkg::SUM_BITS'(price_reg);
            slot_next = slot_reg + 1'b1;
            if (count_reg < mavg_pkg::LEN_BITS'(mavg_pkg::MAX_WINDOW))
                count_next = count_reg + 1'b1;
        end
        if (cmd.upd)
        begin
            if (seeded_reg)
            begin
                if (neg_reg)
                    acc_next = acc_reg - scale[mavg_pkg::ACC_BITS-1:0];
                else
                    acc_next = acc_reg + scale[mavg_pkg::ACC_BITS-1:0];
            end
            else if (sma_ok_reg)
            begin
                acc_next    = {quot_reg[mavg_pkg::PRICE_BITS-1:0],
                               mavg_pkg::FRAC_BITS'(0)};
                seeded_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            acc_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            seeded_reg <= seeded_next;
        end
    end

    // sample ring, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            rdata_reg <= ring_mem[old_slot];
        if (cmd.sum)
            ring_mem[slot_reg] <= price_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            price_reg <= price_sample;
            start_reg <= series_start;
        end
        if (cmd.sum)
        begin
            sma_ok_reg <= (count_next >= eff_len);
            quot_reg   <= sum_next;
            rem_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[mavg_pkg::SUM_BITS-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[mavg_pkg::LEN_BITS-1:0]
                               : rem_shift[mavg_pkg::LEN_BITS-1:0];
        end
        if (cmd.diff)
        begin
            neg_reg  <= (target < acc_reg);
            diff_reg <= (target < acc_reg) ? (acc_reg - target) : (target - acc_reg);
        end
        if (cmd.mul)
        begin
            p_hi_reg <= mavg_pkg::PROD_BITS'(diff_reg[mavg_pkg::ACC_BITS-1:mavg_pkg::FRAC_BITS])
                        * mavg_pkg::PROD_BITS'(eff_weight);
            p_lo_reg <= p_lo_full[mavg_pkg::LO_BITS-1:mavg_pkg::FRAC_BITS];
        end
        if (cmd.out_load)
        begin
            sma_valid_reg <= sma_ok_reg;
            sma_value_reg <= sma_ok_reg ? quot_reg[mavg_pkg::PRICE_BITS-1:0] : '0;
            ema_valid_reg <= seeded_reg;
            ema_value_reg <= seeded_reg ? acc_reg[mavg_pkg::ACC_BITS-1:mavg_pkg::FRAC_BITS]
                                        : '0;
        end
    end

    assign sma_valid = sma_valid_reg;
    assign sma_value = sma_value_reg;
    assign ema_valid = ema_valid_reg;
    assign ema_value = ema_value_reg;

endmodule

`default_nettype wire
